>>> src/rgb565_nearest_neighbor_downscale_assert.svh
// ----------------------------------------------------------------------------
// RGB565 downscaler assertion macros
// Shared property forms for the port-level checks of the downscaler.
// ----------------------------------------------------------------------------
`ifndef RGB565_NEAREST_NEIGHBOR_DOWNSCALE_ASSERT_SVH
`define RGB565_NEAREST_NEIGHBOR_DOWNSCALE_ASSERT_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define RNND_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rnnd: assertion failed");

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define RNND_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rnnd: assertion failed");

`endif

>>> src/rnnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnd_pkg
// Types and fixed constants of the RGB565 nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package rnnd_pkg;

  localparam int CFG_W   = 11;
  localparam int PIX_W   = 16;
  localparam int COLOR_W = 8;
  localparam int POS_W   = 10;
  localparam int IDX_W   = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd96;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   out_col;
    logic [POS_W-1:0]   out_row;
    logic               frame_last;
  } result_t;

endpackage

>>> src/rnnd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnd_in_if / rnnd_out_if
// Valid/ready channels for source pixels and for emitted output pixels.
// ----------------------------------------------------------------------------
interface rnnd_in_if;
  logic                         valid;
  logic                         ready;
  logic [rnnd_pkg::PIX_W-1:0]   pixel565;
  logic                         frame_start;

  modport source (output valid, output pixel565, output frame_start, input ready);
  modport sink (input valid, input pixel565, input frame_start, output ready);
endinterface

interface rnnd_out_if;
  logic                         valid;
  logic                         ready;
  logic [rnnd_pkg::COLOR_W-1:0] red;
  logic [rnnd_pkg::COLOR_W-1:0] green;
  logic [rnnd_pkg::COLOR_W-1:0] blue;
  logic [rnnd_pkg::POS_W-1:0]   out_col;
  logic [rnnd_pkg::POS_W-1:0]   out_row;
  logic                         frame_last;

  modport source (output valid, output red, output green, output blue, output out_col,
                  output out_row, output frame_last, input ready);
  modport sink (input valid, input red, input green, input blue, input out_col,
                input out_row, input frame_last, output ready);
endinterface

>>> src/rgb565_nearest_neighbor_downscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_nearest_neighbor_downscale
// Streaming RGB565 nearest-neighbor downscaler with 8-bit color output.
// ----------------------------------------------------------------------------
// The block takes one RGB565 pixel per clock in raster order and passes on
// only the pixels picked for the output grid, widened to 8-bit color, with
// their output column and row. A pixel is registered on acceptance and judged
// in the next cycle by one pass of adds and compares against the position
// sums; a picked pixel then moves into the output register. The sustained
// rate is one pixel per clock; the input side stalls only while a result
// waits in the output register and the sink holds ready low. Size writes
// reach the datapath through the size registers and then the clamped-size
// registers.
module rgb565_nearest_neighbor_downscale #(
  parameter int MAX_DIM = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rnnd_in_if.sink                    in_ch,
  rnnd_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [rnnd_pkg::IDX_W-1:0] cfg_index,
  input  logic [rnnd_pkg::CFG_W-1:0] cfg_data
);

  localparam int DIM_W = $clog2(MAX_DIM+1);

  logic [DIM_W-1:0] src_w, src_h, out_w, out_h;

  logic                       in_valid_r;
  logic [rnnd_pkg::PIX_W-1:0] pixel_r;
  logic                       frame_start_r;
  logic                       in_accept, advance, emit;

  rnnd_pkg::result_t result, result_r;
  logic              out_valid_r, out_valid_nxt;

  rnnd_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_w     (src_w),
    .src_h     (src_h),
    .out_w     (out_w),
    .out_h     (out_h)
  );

  // The held request moves on whenever the result register is free or being read.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pixel_r       <= in_ch.pixel565;
      frame_start_r <= in_ch.frame_start;
    end
  end

  rnnd_core #(.MAX_DIM(MAX_DIM)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .pixel565    (pixel_r),
    .frame_start (frame_start_r),
    .src_w       (src_w),
    .src_h       (src_h),
    .out_w       (out_w),
    .out_h       (out_h),
    .emit        (emit),
    .result      (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = result_r.red;
  assign out_ch.green      = result_r.green;
  assign out_ch.blue       = result_r.blue;
  assign out_ch.out_col    = result_r.out_col;
  assign out_ch.out_row    = result_r.out_row;
  assign out_ch.frame_last = result_r.frame_last;

endmodule

>>> src/rnnd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnd_cfg
// Size registers and the registered, clamped sizes used by the datapath.
// ----------------------------------------------------------------------------
module rnnd_cfg #(
  parameter int MAX_DIM = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rnnd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [rnnd_pkg::CFG_W-1:0]     cfg_data,
  output logic [$clog2(MAX_DIM+1)-1:0]   src_w,
  output logic [$clog2(MAX_DIM+1)-1:0]   src_h,
  output logic [$clog2(MAX_DIM+1)-1:0]   out_w,
  output logic [$clog2(MAX_DIM+1)-1:0]   out_h
);

  localparam int DIM_W = $clog2(MAX_DIM+1);
  localparam int CMP_W = (DIM_W > rnnd_pkg::CFG_W) ? DIM_W : rnnd_pkg::CFG_W;

  logic [rnnd_pkg::CFG_W-1:0] src_width_r, src_height_r, out_width_r, out_height_r;
  logic [DIM_W-1:0] sw_nxt, sh_nxt, ow_nxt, oh_nxt;
  logic [DIM_W-1:0] src_w_r, src_h_r, out_w_r, out_h_r;

  // Zero reads as one; anything above the limit saturates to the limit.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CMP_W-1:0] v,
                                                 input logic [CMP_W-1:0] hi);
    logic [CMP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CMP_W'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return DIM_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= rnnd_pkg::DIM_RESET;
      src_height_r <= rnnd_pkg::DIM_RESET;
      out_width_r  <= rnnd_pkg::DIM_RESET;
      out_height_r <= rnnd_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (rnnd_pkg::cfg_reg_t'(cfg_index))
        rnnd_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data;
        rnnd_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data;
        rnnd_pkg::REG_OUT_WIDTH:  out_width_r  <= cfg_data;
        rnnd_pkg::REG_OUT_HEIGHT: out_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_nxt = clamp_dim(CMP_W'(src_width_r), CMP_W'(MAX_DIM));
    sh_nxt = clamp_dim(CMP_W'(src_height_r), CMP_W'(MAX_DIM));
    ow_nxt = clamp_dim(CMP_W'(out_width_r), CMP_W'(sw_nxt));
    oh_nxt = clamp_dim(CMP_W'(out_height_r), CMP_W'(sh_nxt));
  end

  // The datapath sees the clamped sizes in these registers, after the size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(1);
      src_h_r <= DIM_W'(1);
      out_w_r <= DIM_W'(1);
      out_h_r <= DIM_W'(1);
    end else begin
      src_w_r <= sw_nxt;
      src_h_r <= sh_nxt;
      out_w_r <= ow_nxt;
      out_h_r <= oh_nxt;
    end
  end

  assign src_w = src_w_r;
  assign src_h = src_h_r;
  assign out_w = out_w_r;
  assign out_h = out_h_r;

endmodule

>>> src/rnnd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnd_core
// Position counters, running sums and the nearest-neighbor pick test.
// ----------------------------------------------------------------------------
module rnnd_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [rnnd_pkg::PIX_W-1:0]     pixel565,
  input  logic                           frame_start,
  input  logic [$clog2(MAX_DIM+1)-1:0]   src_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]   src_h,
  input  logic [$clog2(MAX_DIM+1)-1:0]   out_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]   out_h,
  output logic                           emit,
  output rnnd_pkg::result_t              result
);

  localparam int DIM_W  = $clog2(MAX_DIM+1);
  localparam int SUM_W  = $clog2(MAX_DIM*MAX_DIM+1);
  localparam int SUMX_W = SUM_W + 1;

  logic [DIM_W-1:0] src_col_r, src_row_r, next_out_col_r, next_out_row_r;
  logic [SUM_W-1:0] col_target_sum_r, row_target_sum_r, col_source_sum_r, row_source_sum_r;
  logic [DIM_W-1:0] src_col_nxt, src_row_nxt, next_out_col_nxt, next_out_row_nxt;
  logic [SUM_W-1:0] col_target_sum_nxt, row_target_sum_nxt;
  logic [SUM_W-1:0] col_source_sum_nxt, row_source_sum_nxt;

  logic [DIM_W-1:0] cur_sc, cur_sr, cur_noc, cur_nor;
  logic [SUM_W-1:0] cur_cts, cur_rts, cur_css, cur_rss;
  logic [DIM_W-1:0] sc_inc;
  logic             active, row_hit, col_hit;

  // A frame start clears the counters before its own pixel is judged.
  always_comb begin
    cur_sc  = frame_start ? '0 : src_col_r;
    cur_sr  = frame_start ? '0 : src_row_r;
    cur_noc = frame_start ? '0 : next_out_col_r;
    cur_nor = frame_start ? '0 : next_out_row_r;
    cur_cts = frame_start ? '0 : col_target_sum_r;
    cur_rts = frame_start ? '0 : row_target_sum_r;
    cur_css = frame_start ? '0 : col_source_sum_r;
    cur_rss = frame_start ? '0 : row_source_sum_r;
  end

  // Source c serves output k when c*out <= k*src < c*out + out.
  always_comb begin
    active  = cur_sr < src_h;
    row_hit = (cur_nor < out_h) && (cur_rss <= cur_rts) &&
              (SUMX_W'(cur_rts) < (SUMX_W'(cur_rss) + SUMX_W'(out_h)));
    col_hit = (cur_noc < out_w) && (cur_css <= cur_cts) &&
              (SUMX_W'(cur_cts) < (SUMX_W'(cur_css) + SUMX_W'(out_w)));
    emit    = active && row_hit && col_hit;
    sc_inc  = cur_sc + DIM_W'(1);
  end

  always_comb begin
    src_col_nxt        = cur_sc;
    src_row_nxt        = cur_sr;
    next_out_col_nxt   = cur_noc;
    next_out_row_nxt   = cur_nor;
    col_target_sum_nxt = cur_cts;
    row_target_sum_nxt = cur_rts;
    col_source_sum_nxt = cur_css;
    row_source_sum_nxt = cur_rss;
    if (active) begin
      if (emit) begin
        next_out_col_nxt   = cur_noc + DIM_W'(1);
        col_target_sum_nxt = cur_cts + SUM_W'(src_w);
      end
      src_col_nxt        = sc_inc;
      col_source_sum_nxt = cur_css + SUM_W'(out_w);
      if (sc_inc >= src_w) begin
        src_col_nxt        = '0;
        col_source_sum_nxt = '0;
        next_out_col_nxt   = '0;
        col_target_sum_nxt = '0;
        if (row_hit) begin
          next_out_row_nxt   = cur_nor + DIM_W'(1);
          row_target_sum_nxt = cur_rts + SUM_W'(src_h);
        end
        src_row_nxt        = cur_sr + DIM_W'(1);
        row_source_sum_nxt = cur_rss + SUM_W'(out_h);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r        <= '0;
      src_row_r        <= '0;
      next_out_col_r   <= '0;
      next_out_row_r   <= '0;
      col_target_sum_r <= '0;
      row_target_sum_r <= '0;
      col_source_sum_r <= '0;
      row_source_sum_r <= '0;
    end else if (step) begin
      src_col_r        <= src_col_nxt;
      src_row_r        <= src_row_nxt;
      next_out_col_r   <= next_out_col_nxt;
      next_out_row_r   <= next_out_row_nxt;
      col_target_sum_r <= col_target_sum_nxt;
      row_target_sum_r <= row_target_sum_nxt;
      col_source_sum_r <= col_source_sum_nxt;
      row_source_sum_r <= row_source_sum_nxt;
    end
  end

  always_comb begin
    result.red        = {pixel565[15:11], 3'b000};
    result.green      = {pixel565[10:5], 2'b00};
    result.blue       = {pixel565[4:0], 3'b000};
    result.out_col    = rnnd_pkg::POS_W'(cur_noc);
    result.out_row    = rnnd_pkg::POS_W'(cur_nor);
    result.frame_last = (cur_noc == (out_w - DIM_W'(1))) &&
                        (cur_nor == (out_h - DIM_W'(1)));
  end

endmodule

>>> src/rnnd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnnd_checker
// Port-level checks of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb565_nearest_neighbor_downscale_assert.svh"

module rnnd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rnnd_pkg::COLOR_W-1:0] red,
  input logic [rnnd_pkg::COLOR_W-1:0] green,
  input logic [rnnd_pkg::COLOR_W-1:0] blue,
  input logic [rnnd_pkg::POS_W-1:0]   out_col,
  input logic [rnnd_pkg::POS_W-1:0]   out_row,
  input logic                         frame_last
);

  rnnd_pkg::result_t payload;
  logic              low_bits_clear;

  assign payload        = {red, green, blue, out_col, out_row, frame_last};
  assign low_bits_clear = (red[2:0] == 3'b000) && (green[1:0] == 2'b00) &&
                          (blue[2:0] == 3'b000);

  `RNND_ASSERT_NXT(a_out_valid_holds, out_valid && !out_ready, out_valid)
  `RNND_ASSERT_NXT(a_out_payload_holds, out_valid && !out_ready, $stable(payload))

  // Widening by shift leaves the low color bits clear.
  `RNND_ASSERT_IMP(a_color_low_bits_zero, out_valid, low_bits_clear)

  // A fresh result always comes from a request taken at the input, passed on by the input register.
  `RNND_ASSERT_IMP(a_result_has_request, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind rgb565_nearest_neighbor_downscale rnnd_checker u_rnnd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .red        (out_ch.red),
  .green      (out_ch.green),
  .blue       (out_ch.blue),
  .out_col    (out_ch.out_col),
  .out_row    (out_ch.out_row),
  .frame_last (out_ch.frame_last)
);

>>> tb/tb_rgb565_nearest_neighbor_downscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb565_nearest_neighbor_downscale
// Self-checking bench for the RGB565 nearest-neighbor downscaler. Each pixel
// request the block takes is also run through a behavioral model of the
// position sums. Every pixel that model picks is queued and compared with the
// next output request. Directed tests cover color extremes, degenerate and
// saturated sizes, the end of a frame, a size change inside a frame and one
// long output stall. Random frames follow under three idle patterns.
// ----------------------------------------------------------------------------
module tb_rgb565_nearest_neighbor_downscale;

  localparam int          CFG_W        = rnnd_pkg::CFG_W;
  localparam int          PIX_W        = rnnd_pkg::PIX_W;
  localparam int          POS_W        = rnnd_pkg::POS_W;
  localparam int          IDX_W        = rnnd_pkg::IDX_W;
  localparam int          MAX_DIM      = 1024;
  localparam int          DRAIN_CYCLES = 8;
  localparam longint      TIMEOUT_NS   = 20_000_000;
  localparam int unsigned FRAME_CAP    = 300;
  localparam int          MAX_REPORTS  = 100;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  rnnd_in_if  in_ch ();
  rnnd_out_if out_ch ();

  rgb565_nearest_neighbor_downscale #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Register copies and position state of the behavioral downscaler.
  logic [CFG_W-1:0] reg_sw, reg_sh, reg_ow, reg_oh;
  int unsigned src_col_pos, src_row_pos, out_col_next, out_row_next;
  int unsigned col_tgt_sum, row_tgt_sum, col_src_sum, row_src_sum;
  int unsigned live_pixels;

  rnnd_pkg::result_t pending_pixels[$];
  rnnd_pkg::result_t got_pixel;
  rnnd_pkg::result_t want_pixel;
  int      errors;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_left;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic bit in_window(int unsigned src_sum, int unsigned tgt_sum,
                                   int unsigned size);
    return (src_sum <= tgt_sum) && (tgt_sum < src_sum + size);
  endfunction

  function automatic string fmt_pixel(rnnd_pkg::result_t p);
    return $sformatf("r=%h g=%h b=%h col=%0d row=%0d last=%b",
                     p.red, p.green, p.blue, p.out_col, p.out_row, p.frame_last);
  endfunction

  function automatic void clear_positions();
    src_col_pos  = 0;
    src_row_pos  = 0;
    out_col_next = 0;
    out_row_next = 0;
    col_tgt_sum  = 0;
    row_tgt_sum  = 0;
    col_src_sum  = 0;
    row_src_sum  = 0;
  endfunction

  // Advances the position state by one source pixel; returns 1 when the
  // pixel lands on the output grid.
  function automatic bit downscale_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                                         output rnnd_pkg::result_t r);
    int unsigned sw, sh, ow, oh;
    bit row_hit, col_hit, emit;
    sw   = eff_dim(reg_sw, MAX_DIM);
    sh   = eff_dim(reg_sh, MAX_DIM);
    ow   = eff_dim(reg_ow, sw);
    oh   = eff_dim(reg_oh, sh);
    r    = '0;
    emit = 1'b0;
    if (fs) clear_positions();
    if (src_row_pos >= sh) return 1'b0;
    live_pixels++;
    row_hit = (out_row_next < oh) && in_window(row_src_sum, row_tgt_sum, oh);
    col_hit = (out_col_next < ow) && in_window(col_src_sum, col_tgt_sum, ow);
    if (row_hit && col_hit) begin
      r.red        = {pix[15:11], 3'b000};
      r.green      = {pix[10:5], 2'b00};
      r.blue       = {pix[4:0], 3'b000};
      r.out_col    = out_col_next[POS_W-1:0];
      r.out_row    = out_row_next[POS_W-1:0];
      r.frame_last = (out_col_next == ow - 1) && (out_row_next == oh - 1);
      emit = 1'b1;
      out_col_next++;
      col_tgt_sum += sw;
    end
    src_col_pos++;
    col_src_sum += ow;
    if (src_col_pos >= sw) begin
      src_col_pos  = 0;
      col_src_sum  = 0;
      out_col_next = 0;
      col_tgt_sum  = 0;
      if (row_hit) begin
        out_row_next++;
        row_tgt_sum += sh;
      end
      src_row_pos++;
      row_src_sum += oh;
    end
    return emit;
  endfunction

  // Valid stays high between back-to-back requests; it drops only for a gap.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    rnnd_pkg::result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.pixel565    <= pix;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (downscale_pixel(pix, fs, r)) pending_pixels.push_back(r);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; set_sizes lowers it after the last write.
  task automatic write_reg(input rnnd_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      rnnd_pkg::REG_SRC_WIDTH:  reg_sw = v;
      rnnd_pkg::REG_SRC_HEIGHT: reg_sh = v;
      rnnd_pkg::REG_OUT_WIDTH:  reg_ow = v;
      rnnd_pkg::REG_OUT_HEIGHT: reg_oh = v;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                           input logic [CFG_W-1:0] ow, input logic [CFG_W-1:0] oh);
    write_reg(rnnd_pkg::REG_SRC_WIDTH, sw);
    write_reg(rnnd_pkg::REG_SRC_HEIGHT, sh);
    write_reg(rnnd_pkg::REG_OUT_WIDTH, ow);
    write_reg(rnnd_pkg::REG_OUT_HEIGHT, oh);
    cfg_we <= 1'b0;
    @(posedge clk);
    @(posedge clk);
  endtask

  // Reset sizes: each pixel starts a frame and lands at the grid origin.
  task automatic test_color_extremes();
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hF800, 1'b1);
    send_pixel(16'h07E0, 1'b1);
    send_pixel(16'h001F, 1'b1);
    send_pixel(16'hA5A5, 1'b1);
  endtask

  // A whole 3x2 frame to a 2x1 grid, then pixels past the last source row.
  task automatic test_small_frame_last();
    int i;
    wait_drain();
    set_sizes(11'd3, 11'd2, 11'd2, 11'd1);
    for (i = 0; i < 8; i++) send_pixel(PIX_W'($urandom_range(0, 65535)), i == 0);
  endtask

  // Zero sizes act as 1 and an output larger than the source is clamped.
  task automatic test_degenerate_sizes();
    wait_drain();
    set_sizes(11'd0, 11'd0, 11'd5, 11'd5);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'h5678, 1'b0);
    send_pixel(16'h9ABC, 1'b0);
    send_pixel(16'hDEF0, 1'b1);
  endtask

  // Narrowing the source while the frame is in its second row.
  task automatic test_size_change_mid_frame();
    int i;
    wait_drain();
    set_sizes(11'd4, 11'd4, 11'd2, 11'd2);
    for (i = 0; i < 5; i++) send_pixel(PIX_W'($urandom_range(0, 65535)), i == 0);
    wait_drain();
    set_sizes(11'd2, 11'd4, 11'd2, 11'd2);
    for (i = 0; i < 5; i++) send_pixel(PIX_W'($urandom_range(0, 65535)), 1'b0);
  endtask

  // All-ones source sizes saturate at MAX_DIM; against a 1000-wide or
  // 1000-tall grid the picked positions show the saturated size early.
  task automatic test_max_sizes();
    int i;
    wait_drain();
    set_sizes(11'd2047, 11'd3, 11'd1000, 11'd1);
    for (i = 0; i < 48; i++) send_pixel(PIX_W'($urandom_range(0, 65535)), i == 0);
    wait_drain();
    set_sizes(11'd1, 11'd2047, 11'd0, 11'd1000);
    for (i = 0; i < 48; i++) send_pixel(PIX_W'($urandom_range(0, 65535)), i == 0);
  endtask

  // The receiver holds ready low long enough for the block to stall its input.
  task automatic test_output_stall();
    int i;
    wait_drain();
    set_sizes(11'd8, 11'd8, 11'd8, 11'd8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 400;
    for (i = 0; i < 64; i++) send_pixel(PIX_W'($urandom_range(0, 65535)), i == 0);
  endtask

  task automatic run_random_frames(input int n_items);
    int unsigned goal, full, len, extra, i;
    int sel, kind, nframes, f;
    logic [CFG_W-1:0] sw, sh, ow, oh;
    logic fs;
    goal = live_pixels + n_items;
    while (live_pixels < goal) begin
      sel = $urandom_range(0, 9);
      sw  = CFG_W'($urandom_range(1, 12));
      sh  = CFG_W'($urandom_range(1, 8));
      ow  = CFG_W'($urandom_range(0, sw + 2));
      oh  = CFG_W'($urandom_range(0, sh + 2));
      if (sel == 0) begin
        sw = CFG_W'($urandom_range(0, 2047));
        sh = CFG_W'($urandom_range(0, 2));
        ow = CFG_W'($urandom_range(0, 2047));
      end else if (sel == 1) begin
        sh = CFG_W'($urandom_range(0, 2047));
        sw = CFG_W'($urandom_range(0, 2));
        oh = CFG_W'($urandom_range(0, 2047));
      end
      wait_drain();
      set_sizes(sw, sh, ow, oh);
      nframes = $urandom_range(1, 4);
      for (f = 0; f < nframes; f++) begin
        full = eff_dim(reg_sw, MAX_DIM) * eff_dim(reg_sh, MAX_DIM);
        if (full > FRAME_CAP) full = FRAME_CAP;
        kind  = $urandom_range(0, 9);
        len   = full;
        extra = 0;
        // Most frames are complete; the rest are cut short, overrun the last
        // row, carry stray frame starts or continue without one.
        case (kind)
          6: extra = $urandom_range(1, 6);
          7, 9: len = $urandom_range(1, full);
          8: len = $urandom_range(1, 24);
          default: ;
        endcase
        for (i = 0; i < len + extra; i++) begin
          if (kind == 8) fs = ($urandom_range(0, 5) == 0);
          else fs = (i == 0) && (kind != 9);
          send_pixel(PIX_W'($urandom_range(0, 65535)), fs);
        end
      end
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_pixel.red        = out_ch.red;
      got_pixel.green      = out_ch.green;
      got_pixel.blue       = out_ch.blue;
      got_pixel.out_col    = out_ch.out_col;
      got_pixel.out_row    = out_ch.out_row;
      got_pixel.frame_last = out_ch.frame_last;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected pixel: expected none, actual %s",
                   $time, fmt_pixel(got_pixel));
      end else begin
        want_pixel = pending_pixels.pop_front();
        if (got_pixel !== want_pixel) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: pixel mismatch: expected %s, actual %s",
                     $time, fmt_pixel(want_pixel), fmt_pixel(got_pixel));
        end
      end
    end
  end

  initial begin
    errors            = 0;
    live_pixels       = 0;
    hold_left         = 0;
    send_idle_pct     = 13;
    recv_idle_pct     = 49;
    reg_sw            = rnnd_pkg::DIM_RESET;
    reg_sh            = rnnd_pkg::DIM_RESET;
    reg_ow            = rnnd_pkg::DIM_RESET;
    reg_oh            = rnnd_pkg::DIM_RESET;
    clear_positions();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= rnnd_pkg::REG_SRC_WIDTH;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.pixel565    <= '0;
    in_ch.frame_start <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_color_extremes();
    test_small_frame_last();
    test_degenerate_sizes();
    test_size_change_mid_frame();
    test_max_sizes();
    test_output_stall();

    send_idle_pct = 13;
    recv_idle_pct = 49;
    run_random_frames(500);
    send_idle_pct = 49;
    recv_idle_pct = 13;
    run_random_frames(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_frames(500);

    wait_drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
